// ----- design/sorted_list_insert_remove_core_macros.svh -----
// Assertion helpers shared by the sorted list design.
`ifndef SORTED_LIST_INSERT_REMOVE_CORE_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/slr_pkg.sv -----
package slr_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned COUNT_W   = 5;

  // Request actions
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  // Response status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_RANGE     = 2'd3;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic              sample;  // latch compare flags against probe
    logic [DATA_W-1:0] probe;   // value compared by every cell
    logic              ins;     // open a slot and shift right
    logic              rem;     // close the slot and shift left
    logic [DATA_W-1:0] data;    // value written into the opened slot
  } cell_ctl_t;

endpackage

// ----- design/slr_req_if.sv -----
interface slr_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic signed [slr_pkg::DATA_W-1:0]   value;
  logic [slr_pkg::POS_W-1:0]           position;

  modport source (output valid, action, value, position, input ready);
  modport sink (input valid, action, value, position, output ready);
endinterface

// ----- design/slr_rsp_if.sv -----
interface slr_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [slr_pkg::COUNT_W-1:0]         count;
  logic signed [slr_pkg::DATA_W-1:0]   read_value;

  modport source (output valid, status, count, read_value, input ready);
  modport sink (input valid, status, count, read_value, output ready);
endinterface

// ----- design/slr_cell.sv -----
// One slot of the ordered store. Compares its entry against the probe and
// trades entries with its neighbors when a slot opens or closes.
module slr_cell (
  input  logic                       clk,
  input  slr_pkg::cell_ctl_t         ctl,
  input  logic                       used,
  input  logic                       left_lt,
  input  logic [slr_pkg::DATA_W-1:0] left_entry,
  input  logic [slr_pkg::DATA_W-1:0] right_entry,
  output logic [slr_pkg::DATA_W-1:0] entry,
  output logic                       lt,
  output logic                       eq
);

  // Latch the ordering flags for the word just taken
  always_ff @(posedge clk) begin
    if (ctl.sample) begin
      lt <= used && ($signed(entry) < $signed(ctl.probe));
      eq <= used && (entry == ctl.probe);
    end
  end

  // Shift right behind the insert point, shift left behind the removed slot
  always_ff @(posedge clk) begin
    if (ctl.ins && !lt) begin
      entry <= left_lt ? ctl.data : left_entry;
    end else if (ctl.rem && !lt) begin
      entry <= right_entry;
    end
  end

endmodule

// ----- design/sorted_list_insert_remove_core.sv -----
// Channel  Dir  Payload                                 Handshake
// req      in   action[1:0] value[31:0] position[3:0]   valid/ready
// rsp      out  status[1:0] count[4:0] read_value[31:0] valid/ready
//
// Each request is handled in order: the accept edge latches per-cell compare
// flags, then the update edge shifts the cell chain and loads the response word.
// The update waits while a previous response word still sits unconsumed.
// A new request is taken while the response waits in its output register.
// Synchronous reset empties the list; entry storage itself is not cleared.
module sorted_list_insert_remove_core #(
  parameter int unsigned DEPTH = slr_pkg::DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  slr_req_if.sink   req,
  slr_rsp_if.source rsp
);

  `include "sorted_list_insert_remove_core_macros.svh"

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [1:0]                    act;
  logic [slr_pkg::DATA_W-1:0]    val;
  logic [slr_pkg::POS_W-1:0]     pos;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;

  logic [slr_pkg::DATA_W-1:0]    entry [DEPTH];
  logic [DEPTH-1:0]              lt_v;
  logic [DEPTH-1:0]              eq_v;
  logic [DEPTH-1:0]              used_v;

  slr_pkg::cell_ctl_t            ctl;
  logic                          accept;
  logic                          upd_go;
  logic                          full;
  logic                          found;
  logic                          read_hit;
  logic [IDX_W-1:0]              ridx;
  logic [1:0]                    status_next;
  logic [slr_pkg::DATA_W-1:0]    rdata_next;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign upd_go    = (state == S_UPD) && (!rsp.valid || rsp.ready);
  assign full      = (count == CNT_W'(DEPTH));
  assign found     = |eq_v;

  // Broadcast control to the chain
  always_comb begin
    ctl.sample = accept;
    ctl.probe  = req.value;
    ctl.ins    = upd_go && (act == slr_pkg::ACT_INSERT) && !full;
    ctl.rem    = upd_go && (act == slr_pkg::ACT_REMOVE) && found;
    ctl.data   = val;
  end

  // Build the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                       left_lt;
    logic [slr_pkg::DATA_W-1:0] left_entry;
    logic [slr_pkg::DATA_W-1:0] right_entry;

    assign used_v[i] = (32'(i) < 32'(count));

    if (i == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = entry[i];
    end else begin : g_body
      assign left_lt    = lt_v[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    slr_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .used        (used_v[i]),
      .left_lt     (left_lt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry[i]),
      .lt          (lt_v[i]),
      .eq          (eq_v[i])
    );
  end

  // Read port and response fields
  assign read_hit = (32'(pos) < 32'(count));
  assign ridx     = IDX_W'(pos);

  always_comb begin
    count_next  = count;
    status_next = slr_pkg::STAT_OK;
    rdata_next  = '0;
    case (act)
      slr_pkg::ACT_INSERT: begin
        if (full) begin
          status_next = slr_pkg::STAT_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      slr_pkg::ACT_REMOVE: begin
        if (found) begin
          count_next = count - CNT_W'(1);
        end else begin
          status_next = slr_pkg::STAT_NOT_FOUND;
        end
      end
      slr_pkg::ACT_CLEAR: begin
        count_next = '0;
      end
      slr_pkg::ACT_READ: begin
        if (read_hit) begin
          rdata_next = entry[ridx];
        end else begin
          status_next = slr_pkg::STAT_RANGE;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // Sequence one request at a time
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_UPD;
      S_UPD:   if (upd_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (upd_go) begin
        count <= count_next;
      end
    end
  end

  // Hold the request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      act <= req.action;
      val <= req.value;
      pos <= req.position;
    end
  end

  // Output register: load on update, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (upd_go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      rsp.status     <= status_next;
      rsp.count      <= slr_pkg::COUNT_W'(count_next);
      rsp.read_value <= rdata_next;
    end
  end

  `SLR_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "count exceeds depth")
  `SLR_ASSERT_NEXT(a_accept_upd, clk, rst, accept, state == S_UPD, "accept did not start update")
  `SLR_ASSERT_NEXT(a_upd_rsp, clk, rst, upd_go, rsp.valid, "update produced no response")
  `SLR_ASSERT_NEXT(a_ins_count, clk, rst, ctl.ins, count == $past(count) + CNT_W'(1), "insert count")

endmodule
